>>> hw/rtl/ldb_pkg.sv
// ----------------------------------------------------------------------------
// ldb_pkg
// Shared types, request codes, register indexes and the step table of the
// LED dimmer brightness control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ldb_pkg;

   localparam int LEVEL_W    = 8;
   localparam int REQ_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int ROM_SIZE   = 16;
   localparam int STEP_COUNT_DEFAULT = 16;

   typedef logic [LEVEL_W-1:0] level_type;

   // Request codes; codes twelve to fifteen are unused and do nothing.
   typedef enum logic [REQ_W-1:0] {
      REQ_TOGGLE    = 4'd0,
      REQ_ON        = 4'd1,
      REQ_OFF       = 4'd2,
      REQ_NIGHT_ON  = 4'd3,
      REQ_NIGHT_OFF = 4'd4,
      REQ_STEP_UP   = 4'd5,
      REQ_STEP_DOWN = 4'd6,
      REQ_FINE_UP   = 4'd7,
      REQ_FINE_DOWN = 4'd8,
      REQ_UP_BY     = 4'd9,
      REQ_DOWN_BY   = 4'd10,
      REQ_SET       = 4'd11
   } req_code_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_BELOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_AMOUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE_AMOUNT = 2'd3;

   localparam level_type NIGHT_LEVEL_RESET   = 8'd10;
   localparam level_type SLOW_BELOW_RESET    = 8'd40;
   localparam level_type FINE_AMOUNT_RESET   = 8'd2;
   localparam level_type COARSE_AMOUNT_RESET = 8'd5;

   localparam level_type LEVEL_MAX        = 8'd255;
   localparam level_type LEVEL_MIN_ON     = 8'd1;
   localparam level_type LAST_ON_RESET    = 8'd128;

   // Geometric brightness steps.
   localparam level_type STEP_ROM [ROM_SIZE] = '{
      8'd5, 8'd7, 8'd9, 8'd12, 8'd16, 8'd20, 8'd26, 8'd34,
      8'd43, 8'd56, 8'd72, 8'd93, 8'd119, 8'd154, 8'd198, 8'd255
   };

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      level_type        step_amount;
      level_type        target_level;
   } req_data_type;

   typedef struct packed {
      level_type level_out;
      logic      changed;
      logic      restart_runtime;
      logic      nightlight_cancel;
      logic      night_mode_on;
   } rsp_data_type;

   typedef struct packed {
      level_type night_level;
      level_type slow_below;
      level_type fine_amount;
      level_type coarse_amount;
   } cfg_type;

   typedef struct packed {
      logic      up_hit;
      level_type up_level;
      logic      down_hit;
      level_type down_level;
   } step_type;

endpackage

`default_nettype wire

>>> hw/rtl/ldb_req_if.sv
// ----------------------------------------------------------------------------
// ldb_req_if
// Request channel: valid/ready handshake carrying one dimmer request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldb_req_if;
   import ldb_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   level_type        step_amount;
   level_type        target_level;

   modport source (output valid, output req_type, output step_amount,
                   output target_level, input ready);
   modport sink   (input valid, input req_type, input step_amount,
                   input target_level, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ldb_rsp_if.sv
// ----------------------------------------------------------------------------
// ldb_rsp_if
// Result channel: valid/ready handshake carrying one dimmer result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldb_rsp_if;
   import ldb_pkg::*;

   logic      valid;
   logic      ready;
   level_type level_out;
   logic      changed;
   logic      restart_runtime;
   logic      nightlight_cancel;
   logic      night_mode_on;

   modport source (output valid, output level_out, output changed,
                   output restart_runtime, output nightlight_cancel,
                   output night_mode_on, input ready);
   modport sink   (input valid, input level_out, input changed,
                   input restart_runtime, input nightlight_cancel,
                   input night_mode_on, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/led_dimmer_brightness_control_unit.sv
// ----------------------------------------------------------------------------
// led_dimmer_brightness_control_unit
// Remote-control dimmer: applies one request item to the brightness state
// and returns one result item for it.
// ----------------------------------------------------------------------------
// Usage.
// Request items arrive on req_ch (valid/ready) and name one of twelve actions
// on the 8-bit brightness level. Every request item gives exactly one result
// item on rsp_ch (valid/ready), carrying the new level, a changed flag, the
// runtime-restart and nightlight-cancel pulses and the night mode flag.
// The four tuning registers are written through csr_we, csr_index and
// csr_data; they should only be written while no request is in flight.
// An accepted request moves from the request register into the result
// register once that is free or being emptied. Throughput is one item per
// cycle while the receiver takes results, set by the single pass through the
// state update logic between the two registers; the state written by one
// item is seen by the next one without a bubble.
// Reset clears the level to zero, sets the last on level to 128, clears
// night mode and loads the register defaults; both channels come up empty.
// When the receiver stalls, the result register holds its item and one more
// request is still taken into the request register; further requests then
// wait until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module led_dimmer_brightness_control_unit #(
   parameter int STEP_COUNT = ldb_pkg::STEP_COUNT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ldb_req_if.sink                             req_ch,
   ldb_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [ldb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ldb_pkg::CSR_DATA_W-1:0] csr_data
);
   import ldb_pkg::*;

   // Request register stage.
   logic         in_valid_ff, in_valid_in;
   req_data_type in_data_ff;

   // Result register stage.
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff;

   cfg_type      cfg;
   rsp_data_type core_rsp;
   logic         advance;

   // The held request moves on whenever the result register is free or
   // is being emptied in this cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff.req_type     <= req_ch.req_type;
         in_data_ff.step_amount  <= req_ch.step_amount;
         in_data_ff.target_level <= req_ch.target_level;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   ldb_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ldb_core #(.STEP_COUNT(STEP_COUNT)) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.level_out         = out_data_ff.level_out;
   assign rsp_ch.changed           = out_data_ff.changed;
   assign rsp_ch.restart_runtime   = out_data_ff.restart_runtime;
   assign rsp_ch.nightlight_cancel = out_data_ff.nightlight_cancel;
   assign rsp_ch.night_mode_on     = out_data_ff.night_mode_on;

endmodule

`default_nettype wire

>>> hw/rtl/ldb_csr_regs.sv
// ----------------------------------------------------------------------------
// ldb_csr_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ldb_csr_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [ldb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ldb_pkg::CSR_DATA_W-1:0] csr_data,
   output ldb_pkg::cfg_type                    cfg
);
   import ldb_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_level   <= NIGHT_LEVEL_RESET;
         cfg_ff.slow_below    <= SLOW_BELOW_RESET;
         cfg_ff.fine_amount   <= FINE_AMOUNT_RESET;
         cfg_ff.coarse_amount <= COARSE_AMOUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NIGHT_LEVEL:   cfg_ff.night_level   <= csr_data;
            CSR_SLOW_BELOW:    cfg_ff.slow_below    <= csr_data;
            CSR_FINE_AMOUNT:   cfg_ff.fine_amount   <= csr_data;
            CSR_COARSE_AMOUNT: cfg_ff.coarse_amount <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ldb_step_search.sv
// ----------------------------------------------------------------------------
// ldb_step_search
// Parallel compare of the current level against the step table, giving the
// next step above and the next step below.
// ----------------------------------------------------------------------------
`default_nettype none

module ldb_step_search #(
   parameter int STEP_COUNT = ldb_pkg::STEP_COUNT_DEFAULT
) (
   input  wire ldb_pkg::level_type level,
   output ldb_pkg::step_type       step
);
   import ldb_pkg::*;

   // Only the entries that exist in the table are ever searched.
   localparam int Used = (STEP_COUNT < ROM_SIZE) ? STEP_COUNT : ROM_SIZE;

   always_comb begin
      step = '0;
      // Walk downwards so that the lowest entry above the level wins.
      for (int i = Used - 1; i >= 0; i--) begin
         if (STEP_ROM[i] > level) begin
            step.up_hit   = 1'b1;
            step.up_level = STEP_ROM[i];
         end
      end
      // Walk upwards so that the highest entry below the level wins.
      for (int i = 0; i < Used; i++) begin
         if (STEP_ROM[i] < level) begin
            step.down_hit   = 1'b1;
            step.down_level = STEP_ROM[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ldb_core.sv
// ----------------------------------------------------------------------------
// ldb_core
// Dimmer state (level, last on level, saved level, night flag) and the
// single-pass next-state and result logic for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ldb_core #(
   parameter int STEP_COUNT = ldb_pkg::STEP_COUNT_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire ldb_pkg::req_data_type req,
   input  wire ldb_pkg::cfg_type      cfg,
   output ldb_pkg::rsp_data_type      rsp
);
   import ldb_pkg::*;

   level_type level_ff, level_in;
   level_type last_on_ff, last_on_in;
   level_type saved_ff, saved_in;
   logic      night_ff, night_in;

   step_type  step;
   logic      do_on;
   logic      do_off;
   logic      leave;
   level_type fine_delta;
   level_type amount;
   logic      chg, rst, cnc;
   logic [LEVEL_W:0] sum;

   ldb_step_search #(.STEP_COUNT(STEP_COUNT)) u_search (
      .level (level_ff),
      .step  (step)
   );

   assign fine_delta = (level_ff < cfg.slow_below) ? cfg.fine_amount : cfg.coarse_amount;
   assign amount = (req.req_type == REQ_FINE_UP || req.req_type == REQ_FINE_DOWN)
                   ? fine_delta : req.step_amount;
   assign sum = {1'b0, level_ff} + {1'b0, amount};

   // Toggle, on, off and set-to-zero share the on/off paths.
   assign do_on  = (req.req_type == REQ_ON) ||
                   (req.req_type == REQ_TOGGLE && level_ff == '0);
   assign do_off = (req.req_type == REQ_OFF) ||
                   (req.req_type == REQ_TOGGLE && level_ff != '0) ||
                   (req.req_type == REQ_SET && req.target_level == '0);
   assign leave  = do_on || do_off || (req.req_type == REQ_NIGHT_OFF);

   always_comb begin
      level_in   = level_ff;
      last_on_in = last_on_ff;
      saved_in   = saved_ff;
      night_in   = night_ff;
      chg = 1'b0;
      rst = 1'b0;
      cnc = 1'b0;

      // Leaving night mode restores the saved level before anything else.
      if (leave && night_ff) begin
         level_in = saved_ff;
         night_in = 1'b0;
         chg      = 1'b1;
      end
      if (do_on && level_in == '0) begin
         level_in = last_on_ff;
         rst      = 1'b1;
         chg      = 1'b1;
      end
      if (do_off && level_in != '0) begin
         last_on_in = level_in;
         level_in   = '0;
         cnc        = 1'b1;
         chg        = 1'b1;
      end

      case (req.req_type)
         REQ_NIGHT_ON: begin
            if (!night_ff) begin
               saved_in = level_ff;
               level_in = cfg.night_level;
               night_in = 1'b1;
               chg      = 1'b1;
            end
         end
         REQ_STEP_UP: begin
            if (!night_ff && step.up_hit) begin
               level_in = step.up_level;
               chg      = 1'b1;
            end
         end
         REQ_STEP_DOWN: begin
            if (!night_ff && step.down_hit) begin
               level_in = step.down_level;
               chg      = 1'b1;
            end
         end
         REQ_FINE_UP, REQ_UP_BY: begin
            if (!night_ff && level_ff != LEVEL_MAX) begin
               level_in = (sum >= {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
               chg      = 1'b1;
            end
         end
         REQ_FINE_DOWN, REQ_DOWN_BY: begin
            if (!night_ff && level_ff != LEVEL_MIN_ON) begin
               if (level_ff == '0) begin
                  rst      = 1'b1;
                  level_in = LEVEL_MIN_ON;
               end else if (level_ff <= amount) begin
                  level_in = LEVEL_MIN_ON;
               end else begin
                  level_in = level_ff - amount;
               end
               chg = 1'b1;
            end
         end
         REQ_SET: begin
            // Non-zero set leaves night mode without restoring the saved level.
            if (req.target_level != '0) begin
               night_in = 1'b0;
               rst      = (level_ff == '0);
               level_in = req.target_level;
               chg      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         last_on_ff <= LAST_ON_RESET;
         saved_ff   <= '0;
         night_ff   <= 1'b0;
      end else if (advance) begin
         level_ff   <= level_in;
         last_on_ff <= last_on_in;
         saved_ff   <= saved_in;
         night_ff   <= night_in;
      end
   end

   assign rsp.level_out         = level_in;
   assign rsp.changed           = chg;
   assign rsp.restart_runtime   = rst;
   assign rsp.nightlight_cancel = cnc;
   assign rsp.night_mode_on     = night_in;

endmodule

`default_nettype wire

>>> hw/rtl/ldb_checker.sv
// ----------------------------------------------------------------------------
// ldb_checker
// Port-level checks on the result channel of the dimmer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ldb_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire ldb_pkg::level_type level_out,
   input wire logic               changed,
   input wire logic               restart_runtime,
   input wire logic               nightlight_cancel
);
   import ldb_pkg::*;

   // The result channel is empty in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid in the cycle after reset");

   // A stalled result holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(level_out) && $stable(changed))
      else $error("stalled result changed");

   // Cancelling a nightlight means the light went off and a change was issued.
   a_cancel_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && nightlight_cancel |-> changed && level_out == '0 && !restart_runtime)
      else $error("nightlight cancel without turn-off");

   // A runtime restart leaves the light on and is always a change.
   a_restart_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && restart_runtime |-> changed && level_out != '0)
      else $error("runtime restart without turn-on");

endmodule

bind led_dimmer_brightness_control_unit ldb_checker u_ldb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .level_out         (rsp_ch.level_out),
   .changed           (rsp_ch.changed),
   .restart_runtime   (rsp_ch.restart_runtime),
   .nightlight_cancel (rsp_ch.nightlight_cancel)
);

`default_nettype wire
